// ===== rtl/core/kbl_pkg.sv =====
// Package for the k-th successor block: field widths, default sizes,
// item structs, codes and the engine state type.
// No dependencies; every other file of the block imports it.
package kbl_pkg;

  // Fixed field widths of the item and configuration formats.
  localparam int NODE_W = 10;
  localparam int CNT_W  = 11;
  localparam int DIST_W = 30;

  // Default sizes for the top-level parameters.
  localparam int DEF_NODES  = 1024;
  localparam int DEF_LEVELS = 30;

  // Codes of the kind field.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // One input beat.
  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] successor;
    logic [DIST_W-1:0] distance;
    logic              last_load;
  } kbl_req_t;

  // One result beat.
  typedef struct packed {
    logic [NODE_W-1:0] end_node;
    logic              error;
  } kbl_res_t;

  // Engine sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIX_RD,
    ST_FIX_CHK,
    ST_BLD_A,
    ST_BLD_B,
    ST_BLD_C,
    ST_QUERY,
    ST_RESP
  } kbl_state_t;

endpackage

// ===== rtl/core/kbl_in_if.sv =====
// Input channel of the k-th successor block: valid/ready plus the item fields.
// Depends on kbl_pkg for the field widths.
interface kbl_in_if import kbl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] successor;
  logic [DIST_W-1:0] distance;
  logic              last_load;

  modport source (output valid, kind, node, successor, distance, last_load, input ready);
  modport sink   (input valid, kind, node, successor, distance, last_load, output ready);
endinterface

// ===== rtl/core/kbl_out_if.sv =====
// Result channel of the k-th successor block: valid/ready plus the result fields.
// Depends on kbl_pkg for the field widths.
interface kbl_out_if import kbl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] end_node;
  logic              error;

  modport source (output valid, end_node, error, input ready);
  modport sink   (input valid, end_node, error, output ready);
endinterface

// ===== rtl/core/kbl_engine.sv =====
// Jump-table engine: holds the table memory, the node count and the build flag,
// and sequences loads, the table build and query walks. Depends on kbl_pkg.
module kbl_engine import kbl_pkg::*; #(
  parameter int NODES  = DEF_NODES,
  parameter int LEVELS = DEF_LEVELS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             req_valid,
  output logic             req_ready,
  input  kbl_req_t         req,
  output logic             res_valid,
  input  logic             res_ready,
  output kbl_res_t         res
);

  localparam int NODE_AW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int MEM_DEPTH = LEVELS * (1 << NODE_AW);
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int RST_CNT   = (NODES < 1024) ? NODES : 1024;

  // Table memory: one row of 2^NODE_AW entries per level.
  logic [NODE_W-1:0] mem [MEM_DEPTH];
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [NODE_W-1:0] rdata_r;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [NODE_W-1:0] wr_data;

  kbl_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  nc_r, nc_nxt;
  logic              built_r, built_nxt;
  logic [NODE_AW-1:0] v_r, v_nxt;
  logic [LVL_W-1:0]  lv_r, lv_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              pend_r, pend_nxt;
  logic              err_r, err_nxt;

  logic              v_last;
  logic              lv_last;
  logic [NODE_W-1:0] cur_eff;
  logic              accept;
  logic [CNT_W-1:0]  cfg_clamped;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [NODE_AW-1:0] idx);
    tbl_addr = ADDR_W'({lvl, idx});
  endfunction

  // Synchronous memory: registered read, one write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nc_r    <= CNT_W'(RST_CNT);
      built_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nc_r    <= nc_nxt;
      built_r <= built_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working registers of the build and the walk.
  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    lv_r   <= lv_nxt;
    cur_r  <= cur_nxt;
    dist_r <= dist_nxt;
    err_r  <= err_nxt;
  end

  // Clamp a written node count into 1..NODES.
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (32'(cfg_wdata) > 32'(NODES)) begin
      cfg_clamped = CNT_W'(NODES);
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  assign v_last    = (32'(v_r) + 32'd1) == 32'(nc_r);
  assign lv_last   = lv_r == LVL_W'(LEVELS - 1);
  assign cur_eff   = pend_r ? rdata_r : cur_r;
  assign req_ready = state_r == ST_IDLE;
  assign accept    = req_valid && req_ready;

  // Sequencer: next state, memory port control and result.
  always_comb begin
    state_nxt = state_r;
    nc_nxt    = nc_r;
    built_nxt = built_r;
    v_nxt     = v_r;
    lv_nxt    = lv_r;
    cur_nxt   = cur_r;
    dist_nxt  = dist_r;
    pend_nxt  = pend_r;
    err_nxt   = err_r;
    rd_en     = 1'b0;
    rd_addr   = tbl_addr('0, v_r);
    wr_en     = 1'b0;
    wr_addr   = tbl_addr('0, v_r);
    wr_data   = NODE_W'(v_r);
    res_valid = 1'b0;
    res.end_node = cur_eff;
    res.error    = err_r;

    if (cfg_we) begin
      nc_nxt    = cfg_clamped;
      built_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (req.kind == KIND_LOAD) begin
            // Level-0 write; an out-of-range successor becomes a self loop.
            built_nxt = 1'b0;
            wr_addr   = tbl_addr('0, NODE_AW'(req.node));
            wr_data   = ({1'b0, req.successor} < nc_r) ? req.successor : req.node;
            wr_en     = {1'b0, req.node} < nc_r;
            if (req.last_load) begin
              state_nxt = ST_FIX_RD;
            end
          end else if (!built_r || ({1'b0, req.node} >= nc_r)) begin
            cur_nxt   = '0;
            err_nxt   = 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = ST_RESP;
          end else begin
            cur_nxt   = req.node;
            err_nxt   = 1'b0;
            pend_nxt  = 1'b0;
            dist_nxt  = req.distance;
            lv_nxt    = '0;
            state_nxt = ST_QUERY;
          end
        end
      end

      ST_FIX_RD: begin
        v_nxt     = '0;
        rd_en     = 1'b1;
        rd_addr   = tbl_addr('0, '0);
        state_nxt = ST_FIX_CHK;
      end

      ST_FIX_CHK: begin
        // Recheck level 0 and issue the read of the next node.
        wr_addr = tbl_addr('0, v_r);
        wr_data = NODE_W'(v_r);
        wr_en   = {1'b0, rdata_r} >= nc_r;
        if (v_last) begin
          if (LEVELS == 1) begin
            built_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            lv_nxt    = LVL_W'(1);
            v_nxt     = '0;
            state_nxt = ST_BLD_A;
          end
        end else begin
          v_nxt   = v_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = tbl_addr('0, v_r + 1'b1);
        end
      end

      ST_BLD_A: begin
        rd_en     = 1'b1;
        rd_addr   = tbl_addr(lv_r - 1'b1, v_r);
        state_nxt = ST_BLD_B;
      end

      ST_BLD_B: begin
        // The midpoint node comes back; look up its jump on the same level.
        rd_en     = 1'b1;
        rd_addr   = tbl_addr(lv_r - 1'b1, NODE_AW'(rdata_r));
        state_nxt = ST_BLD_C;
      end

      ST_BLD_C: begin
        wr_en   = 1'b1;
        wr_addr = tbl_addr(lv_r, v_r);
        wr_data = rdata_r;
        if (v_last) begin
          v_nxt = '0;
          if (lv_last) begin
            built_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            // A new level starts with a separate read cycle, so it never
            // reads the entry being written now.
            lv_nxt    = lv_r + 1'b1;
            state_nxt = ST_BLD_A;
          end
        end else begin
          v_nxt     = v_r + 1'b1;
          rd_en     = 1'b1;
          rd_addr   = tbl_addr(lv_r - 1'b1, v_r + 1'b1);
          state_nxt = ST_BLD_B;
        end
      end

      ST_QUERY: begin
        // One level per cycle; the read data of the last jump feeds the next
        // address directly.
        cur_nxt  = cur_eff;
        pend_nxt = dist_r[0];
        rd_en    = dist_r[0];
        rd_addr  = tbl_addr(lv_r, NODE_AW'(cur_eff));
        dist_nxt = dist_r >> 1;
        lv_nxt   = lv_r + 1'b1;
        if (lv_last || (dist_r[DIST_W-1:1] == '0)) begin
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/kth_successor_binary_lifting.sv =====
// A last load beat starts the table build: a level-0 check pass over node_count nodes, then
// a read-read-write pass per higher level, bound by the single table read port.
// A query walks one level per distance bit up to its highest set bit (at least 1, at
// most LEVELS), since each jump waits on the previous read; a failing query goes straight to the result.
// Synchronous active-low reset empties the output register, clears the built flag and sets
// node_count to min(NODES, 1024); the table is kept. Needs kbl_pkg, the interfaces, kbl_engine.
module kth_successor_binary_lifting import kbl_pkg::*; #(
  parameter int NODES  = DEF_NODES,
  parameter int LEVELS = DEF_LEVELS
) (
  input  logic             clk,
  input  logic             rst_n,
  kbl_in_if.sink           in_ch,
  kbl_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  kbl_req_t req;
  kbl_res_t res;
  logic     res_valid;
  logic     res_ready;
  logic     out_valid_r;
  kbl_res_t out_data_r;

  // Gather the input beat into one struct.
  assign req.kind      = in_ch.kind;
  assign req.node      = in_ch.node;
  assign req.successor = in_ch.successor;
  assign req.distance  = in_ch.distance;
  assign req.last_load = in_ch.last_load;

  kbl_engine #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.end_node = out_data_r.end_node;
  assign out_ch.error    = out_data_r.error;

endmodule
